FILE: design/awd_pkg.sv
package awd_pkg;

  localparam int NSTAGE = 8;

  localparam int WFRAC = 23;
  localparam int XW    = 24;
  localparam int GW    = 27;
  localparam int AW    = 31;
  localparam int DW    = 28;
  localparam int QW    = 9;
  localparam int QTW   = 36;
  localparam int RW    = 38;
  localparam int VW    = 32;
  localparam int FW    = 25;
  localparam int WW    = 23;
  localparam int TRW   = 27;
  localparam int G2W   = 2 * GW - WFRAC;
  localparam int G3W   = 31;
  localparam int DIVW  = G3W - 1;
  localparam int WETW  = 40;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 21;

  localparam logic [1:0] MODE_SOFT = 2'd0;
  localparam logic [1:0] MODE_HARD = 2'd1;
  localparam logic [1:0] MODE_FOLD = 2'd2;
  localparam logic [1:0] MODE_TRI  = 2'd3;

  localparam logic [CFG_IW-1:0] REG_SHAPE_MODE    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_WET_MIX       = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DRIVE_FACTOR  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CLIP_LEVEL    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FOLD_PERIOD   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_TRI_GAIN_DB   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_TRI_RATIO     = 3'd6;

  localparam logic [16:0] MIX_FULL = 17'd65536;

  localparam logic signed [WETW-1:0] TWO_THIRDS_W = 40'sd5592405;
  localparam logic signed [WETW-1:0] ONE_W        = 40'sd8388608;
  localparam logic signed [VW-1:0]   HALF_V       = 32'sd4194304;
  localparam logic signed [FW-1:0]   HALF_F       = 25'sd4194304;
  localparam logic signed [FW-1:0]   QUARTER_F    = 25'sd2097152;
  localparam logic [31:0]            DIV3_MUL     = 32'hAAAAAAAB;

  typedef logic signed [XW-1:0]   smp_t;
  typedef logic signed [GW-1:0]   gain_t;
  typedef logic signed [AW-1:0]   tri_acc_t;
  typedef logic signed [WETW-1:0] wet_t;

  typedef struct packed {
    logic [1:0]         shape_mode;
    logic [16:0]        wet_mix;
    logic [17:0]        drive_factor;
    logic [17:0]        clip_level;
    logic [20:0]        fold_period_inverse;
    logic signed [14:0] tri_gain_db;
    logic [19:0]        tri_ratio;
  } awd_cfg_t;

  typedef struct packed {
    smp_t     x;
    gain_t    g;
    tri_acc_t a;
  } awd_front_t;

  typedef struct packed {
    smp_t x;
    wet_t wet;
  } awd_wet_t;

endpackage

FILE: design/awd_front.sv
module awd_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [SAMPLE_BITS-1:0] dry,
  input  awd_pkg::awd_cfg_t             cfg,
  output awd_pkg::awd_front_t           front
);
  import awd_pkg::*;

  smp_t                  x_nxt;
  smp_t                  x0_r;
  logic signed [GW+15:0] gp;
  logic signed [AW+7:0]  ap;
  awd_front_t            front_r;

  // bring the sample to q.23
  generate
    if (SAMPLE_BITS >= XW) begin : g_narrow
      localparam int SH = SAMPLE_BITS - XW;
      logic signed [SAMPLE_BITS-1:0] shifted;
      assign shifted = dry >>> SH;
      assign x_nxt   = shifted[XW-1:0];
    end else begin : g_widen
      localparam int PAD = XW - SAMPLE_BITS;
      assign x_nxt = {dry, {PAD{1'b0}}};
    end
  endgenerate

  assign gp = x0_r * $signed({1'b0, cfg.drive_factor});
  assign ap = x0_r * cfg.tri_gain_db;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r <= x_nxt;
    end
    if (en[1]) begin
      front_r.x <= x0_r;
      front_r.g <= gp[GW+15:16];
      front_r.a <= ap[AW+7:8];
    end
  end

  assign front = front_r;

endmodule

FILE: design/awd_shaper.sv
module awd_shaper (
  input  logic                clk,
  input  logic [3:0]          en,
  input  awd_pkg::awd_cfg_t   cfg,
  input  awd_pkg::awd_front_t front,
  output awd_pkg::awd_wet_t   shaped
);
  import awd_pkg::*;

  // shared threshold and ratio views
  logic [24:0]            t_u;
  logic signed [DW-1:0]   t_s;
  logic [TRW-1:0]         r_u;
  wet_t                   t_w;

  // stage 2 logic
  logic signed [DW-1:0]   g_e;
  logic signed [DW-1:0]   d;
  logic signed [DW-1:0]   d_abs;
  logic [DW+19:0]         qp;
  logic signed [2*GW-1:0] gg;
  logic signed [VW-1:0]   v;
  logic signed [VW-1:0]   u;
  logic signed [FW-1:0]   e;
  logic signed [FW-1:0]   f;
  logic signed [FW-1:0]   fq;
  logic signed [FW-1:0]   fq_abs;

  smp_t                   x2_r;
  gain_t                  g2_r;
  logic                   lo2_r, hi2_r, fin2_r;
  logic signed [G2W-1:0]  sq2_r;
  logic signed [DW-1:0]   d2_r;
  logic [QW-1:0]          q2_r;
  logic [WW-1:0]          w2_r;

  // stage 3 logic
  logic signed [G2W+GW-1:0] cube;
  logic [QW+24:0]           qt;
  logic [TRW+WW-1:0]        tw;

  smp_t                   x3_r;
  gain_t                  g3_r;
  logic                   lo3_r, hi3_r, fin3_r;
  logic signed [G3W-1:0]  cube3_r;
  logic signed [DW-1:0]   d3_r;
  logic [QTW-1:0]         qt3_r;
  logic [TRW-1:0]         tw3_r;

  // stage 4 logic
  logic signed [G3W-1:0]  g3a;
  logic [G3W+31:0]        divp;
  logic signed [RW-1:0]   d_x;
  logic signed [RW-1:0]   qt_s;

  smp_t                   x4_r;
  gain_t                  g4_r;
  logic                   lo4_r, hi4_r, fin4_r;
  logic [DIVW-1:0]        div4_r;
  logic                   neg4_r;
  logic signed [RW-1:0]   rf4_r;
  logic [TRW-1:0]         tw4_r;

  // stage 5 logic
  wet_t                   g_w;
  wet_t                   div_w;
  wet_t                   soft_v;
  logic signed [RW-1:0]   r_abs;
  wet_t                   fa;
  wet_t                   fb;
  wet_t                   fold_v;
  wet_t                   wet_nxt;

  smp_t                   x5_r;
  wet_t                   wet5_r;

  assign t_u = {cfg.clip_level, 7'b0};
  assign t_s = $signed({3'b0, t_u});
  assign r_u = {cfg.tri_ratio, 7'b0};
  assign t_w = wet_t'($signed({1'b0, t_u}));

  // compare, fold quotient, square, triangle phase
  assign g_e   = DW'(front.g);
  assign d     = g_e - t_s;
  assign d_abs = d[DW-1] ? -d : d;
  assign qp    = d_abs[DW-2:0] * cfg.fold_period_inverse;
  assign gg    = front.g * front.g;

  assign v      = VW'(front.a) + $signed({5'b0, r_u});
  assign u      = v[VW-1] ? (HALF_V - v) : (v + HALF_V);
  assign e      = $signed({2'b0, u[WFRAC-1:0]}) - HALF_F;
  assign f      = v[VW-1] ? -e : e;
  assign fq     = f - QUARTER_F;
  assign fq_abs = fq[FW-1] ? -fq : fq;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x2_r   <= front.x;
      g2_r   <= front.g;
      lo2_r  <= (g_e <= -t_s);
      hi2_r  <= (g_e >= t_s);
      fin2_r <= (g_e <= t_s) && (g_e >= -t_s);
      sq2_r  <= gg[2*GW-1:WFRAC];
      d2_r   <= d;
      q2_r   <= qp[DW+19:39];
      w2_r   <= fq_abs[WW-1:0];
    end
  end

  // cube, fold multiple, triangle scale
  assign cube = sq2_r * g2_r;
  assign qt   = q2_r * t_u;
  assign tw   = r_u * w2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x3_r    <= x2_r;
      g3_r    <= g2_r;
      lo3_r   <= lo2_r;
      hi3_r   <= hi2_r;
      fin3_r  <= fin2_r;
      cube3_r <= cube[G3W+WFRAC-1:WFRAC];
      d3_r    <= d2_r;
      qt3_r   <= {qt, 2'b0};
      tw3_r   <= tw[TRW+WW-1:WFRAC];
    end
  end

  // divide the cube by three, fold remainder
  assign g3a  = cube3_r[G3W-1] ? -cube3_r : cube3_r;
  assign divp = g3a * DIV3_MUL;
  assign d_x  = RW'(d3_r);
  assign qt_s = $signed({2'b0, qt3_r});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x4_r   <= x3_r;
      g4_r   <= g3_r;
      lo4_r  <= lo3_r;
      hi4_r  <= hi3_r;
      fin4_r <= fin3_r;
      div4_r <= divp[G3W+31:33];
      neg4_r <= cube3_r[G3W-1];
      rf4_r  <= d3_r[DW-1] ? (d_x + qt_s) : (d_x - qt_s);
      tw4_r  <= tw3_r;
    end
  end

  // pick the shaped value
  assign g_w    = wet_t'(g4_r);
  assign div_w  = wet_t'($signed({1'b0, div4_r}));
  assign soft_v = neg4_r ? (g_w + div_w) : (g_w - div_w);
  assign r_abs  = rf4_r[RW-1] ? -rf4_r : rf4_r;
  assign fa     = wet_t'(r_abs) - (t_w <<< 1);
  assign fb     = fa[WETW-1] ? -fa : fa;
  assign fold_v = fb - t_w;

  always_comb begin
    case (cfg.shape_mode)
      MODE_SOFT: begin
        if (lo4_r) begin
          wet_nxt = -TWO_THIRDS_W;
        end else if (hi4_r) begin
          wet_nxt = TWO_THIRDS_W;
        end else begin
          wet_nxt = soft_v;
        end
      end
      MODE_HARD: begin
        if (lo4_r) begin
          wet_nxt = -ONE_W;
        end else if (hi4_r) begin
          wet_nxt = ONE_W;
        end else begin
          wet_nxt = g_w;
        end
      end
      MODE_FOLD: begin
        wet_nxt = fin4_r ? g_w : fold_v;
      end
      MODE_TRI: begin
        wet_nxt = wet_t'($signed({1'b0, tw4_r}));
      end
      default: begin
        wet_nxt = g_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x5_r   <= x4_r;
      wet5_r <= wet_nxt;
    end
  end

  assign shaped.x   = x5_r;
  assign shaped.wet = wet5_r;

endmodule

FILE: design/awd_mix.sv
module awd_mix #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  awd_pkg::awd_cfg_t             cfg,
  input  awd_pkg::awd_wet_t             shaped,
  output logic signed [SAMPLE_BITS-1:0] sample
);
  import awd_pkg::*;

  localparam int PDW  = XW + 18;
  localparam int PWW  = WETW + 18;
  localparam int SUMW = PWW + 1;
  localparam int MW   = SUMW - 16;
  localparam int YW   = MW + 8;

  logic [16:0]                  m;
  logic [16:0]                  dm;
  logic signed [PDW-1:0]        pd;
  logic signed [PWW-1:0]        pw;
  logic signed [PDW-1:0]        pd6_r;
  logic signed [PWW-1:0]        pw6_r;
  logic signed [SUMW-1:0]       sum;
  logic signed [YW-1:0]         ext;
  logic signed [YW-1:0]         y;
  logic [YW-SAMPLE_BITS:0]      top;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic signed [SAMPLE_BITS-1:0] out_nxt;
  logic signed [SAMPLE_BITS-1:0] out_r;

  assign m  = (cfg.wet_mix > MIX_FULL) ? MIX_FULL : cfg.wet_mix;
  assign dm = MIX_FULL - m;
  assign pd = shaped.x * $signed({1'b0, dm});
  assign pw = shaped.wet * $signed({1'b0, m});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pd6_r <= pd;
      pw6_r <= pw;
    end
  end

  assign sum = SUMW'(pw6_r) + SUMW'(pd6_r);
  assign ext = YW'($signed(sum[SUMW-1:16]));

  // back to the port format
  generate
    if (SAMPLE_BITS >= XW) begin : g_up
      localparam int SH = SAMPLE_BITS - XW;
      assign y = ext <<< SH;
    end else begin : g_down
      localparam int SH = XW - SAMPLE_BITS;
      assign y = ext >>> SH;
    end
  endgenerate

  assign top     = y[YW-1:SAMPLE_BITS-1];
  assign sat     = y[YW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  assign out_nxt = ((&top) || !(|top)) ? y[SAMPLE_BITS-1:0] : sat;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out_r <= out_nxt;
    end
  end

  assign sample = out_r;

endmodule

FILE: design/audio_waveshaper_distortion_unit.sv
// Waveshaper distortion: each input item is one signed audio sample, scaled by
// the drive factor (triangle gain in triangle mode), shaped by soft clip, hard
// clip, foldback or triangle fold, mixed with the dry sample by the wet share
// and saturated to the sample width. One item can enter the eight-stage
// register pipeline (input capture, drive multiply, square, cube, divide by
// three, shape select, mix multiply, sum and saturate) every clock cycle while
// the input is not stalled. Each stage holds its item while the one after it
// is full and stalled, so empty stages fill even when the output is held.
// Write the configuration registers only while no item is in flight.
module audio_waveshaper_distortion_unit #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    in_dry_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    out_sample,
  input  logic                             cfg_we,
  input  logic [awd_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [awd_pkg::CFG_DW-1:0]       cfg_wdata
);
  import awd_pkg::*;

  awd_cfg_t          cfg_r;
  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] valid_nxt;
  logic [NSTAGE-1:0] en;
  logic              in_acc;
  logic              out_acc;
  awd_front_t        front;
  awd_wet_t          shaped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shape_mode          <= MODE_SOFT;
      cfg_r.wet_mix             <= 17'd32768;
      cfg_r.drive_factor        <= 18'd74797;
      cfg_r.clip_level          <= 18'd65536;
      cfg_r.fold_period_inverse <= 21'd16384;
      cfg_r.tri_gain_db         <= -15'sd4352;
      cfg_r.tri_ratio           <= 20'd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAPE_MODE:   cfg_r.shape_mode          <= cfg_wdata[1:0];
        REG_WET_MIX:      cfg_r.wet_mix             <= cfg_wdata[16:0];
        REG_DRIVE_FACTOR: cfg_r.drive_factor        <= cfg_wdata[17:0];
        REG_CLIP_LEVEL:   cfg_r.clip_level          <= cfg_wdata[17:0];
        REG_FOLD_PERIOD:  cfg_r.fold_period_inverse <= cfg_wdata[20:0];
        REG_TRI_GAIN_DB:  cfg_r.tri_gain_db         <= $signed(cfg_wdata[14:0]);
        REG_TRI_RATIO:    cfg_r.tri_ratio           <= cfg_wdata[19:0];
        default: begin
        end
      endcase
    end
  end

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    en[NSTAGE-1] = !valid_r[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  assign valid_nxt = (en & {valid_r[NSTAGE-2:0], in_valid}) | (~en & valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid_r[NSTAGE-1];
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  awd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk   (clk),
    .en    (en[1:0]),
    .dry   (in_dry_sample),
    .cfg   (cfg_r),
    .front (front)
  );

  awd_shaper u_shaper (
    .clk    (clk),
    .en     (en[5:2]),
    .cfg    (cfg_r),
    .front  (front),
    .shaped (shaped)
  );

  awd_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk    (clk),
    .en     (en[7:6]),
    .cfg    (cfg_r),
    .shaped (shaped),
    .sample (out_sample)
  );

  a_fill_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !(&valid_r) |-> !in_stall)
    else $error("input stalled with an empty stage");

  a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r) ==
              $past($countones(valid_r)) + $past(in_acc) - $past(out_acc)))
    else $error("item lost or duplicated in pipeline");

endmodule
